>>> hdl/windowed_sinc_fir_decimator_defines.svh
// Assertion helpers shared by the checker.
`ifndef WINDOWED_SINC_FIR_DECIMATOR_DEFINES_SVH
`define WINDOWED_SINC_FIR_DECIMATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WSFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/wsfd_pkg.sv
package wsfd_pkg;

  localparam int TAPS       = 95;
  localparam int OVERSAMPLE = 4;
  localparam int FS_OUT_HZ  = 48000;
  localparam int CORNER_HZ  = 20000;

  localparam int TapW    = $clog2(TAPS);
  localparam int PhW     = $clog2(OVERSAMPLE);
  localparam int SampleW = 24;
  localparam int CoefW   = 18;
  localparam int ProdW   = SampleW + CoefW;
  localparam int AccW    = 48;
  localparam int RoundSh = 17;

  localparam longint unsigned PiQ30     = 64'd3373259426;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // inner sample rate and the center tap of the sinc
  localparam longint unsigned InnerHz    = 64'(FS_OUT_HZ) * 64'(OVERSAMPLE);
  localparam longint          CenterSinc = longint'(PiQ30 * 64'(CORNER_HZ) / InnerHz);

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;
  typedef coef_t coef_rom_t [TAPS];

  localparam coef_t CoefMax = 18'sh1FFFF;
  localparam coef_t CoefMin = 18'sh20000;

  // Controls from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clr;
    logic mul_en;
  } mac_ctrl_t;

  // The functions below only run at elaboration to build the coefficient table.

  // shift-subtract quotient; operands stay below 2^63
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned umod64(longint unsigned n, longint unsigned d);
    return n - udiv64(n, d) * d;
  endfunction

  // signed quotient, truncated toward zero
  function automatic longint sdiv64(longint n, longint unsigned d);
    longint unsigned mag;
    mag = udiv64((n < 0) ? 64'(-n) : 64'(n), d);
    return (n < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned isqrt64(longint unsigned v_in);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    v = v_in;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // sin(2*pi*t/2^32) in Q30
  function automatic longint sin_turn_q30(int unsigned t);
    int unsigned     quad;
    longint unsigned f;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint unsigned den;
    longint          acc;
    quad = t >> 30;
    f    = 64'(t & 32'h3FFF_FFFF);
    if (quad[0]) f = 64'h4000_0000 - f;
    a    = (f * HalfPiQ30) >> 30;
    a2   = (a * a) >> 30;
    term = a;
    acc  = longint'(a);
    for (int j = 1; j <= 7; j++) begin
      den  = 64'((2 * j) * (2 * j + 1));
      term = udiv64((term * a2) >> 30, den);
      if (j % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    return quad[1] ? -acc : acc;
  endfunction

  // Kaiser window, Q16, not normalized
  function automatic longint window_q16(int k);
    longint          m;
    longint unsigned d;
    longint unsigned root;
    longint unsigned y;
    longint unsigned half;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned jj;
    m    = longint'(TAPS - 1);
    d    = m * m - longint'(k) * longint'(k);
    root = isqrt64(d << 40);
    y    = udiv64(root * 64'd16 * 64'd86, 64'(10 * m));
    half = y / 64'd2;
    term = 64'd1 << 24;
    acc  = term;
    for (int j = 1; j < 24; j++) begin
      jj   = 64'(j);
      term = udiv64((term * half) >> 24, jj);
      acc  = acc + ((term * term) >> 24);
    end
    return longint'(acc >> 8);
  endfunction

  function automatic coef_rom_t build_rom();
    longint          raw [TAPS];
    longint          total;
    longint unsigned tot_u;
    longint unsigned num;
    longint unsigned mag;
    longint unsigned q;
    int              k;
    int unsigned     ak;
    int unsigned     t;
    longint          s;
    bit              neg;
    coef_rom_t       rom;
    total = 0;
    for (int n = 0; n < TAPS; n++) begin
      k  = 2 * n - (TAPS - 1);
      ak = unsigned'((k < 0) ? -k : k);
      if (ak == 0) begin
        s = CenterSinc;
      end else begin
        num = 64'(CORNER_HZ / 2) * 64'(ak);
        t   = 32'(udiv64(umod64(num, InnerHz) << 32, InnerHz));
        s   = sdiv64(sin_turn_q30(t), 64'(ak));
      end
      raw[n] = (s * window_q16(k)) / 64'sd65536;
      total  = total + raw[n];
    end
    tot_u = total;
    for (int n = 0; n < TAPS; n++) begin
      if (total <= 0) begin
        rom[n] = (n == (TAPS - 1) / 2) ? CoefMax : coef_t'(0);
      end else begin
        neg = raw[n] < 0;
        mag = neg ? -raw[n] : raw[n];
        q   = udiv64(mag * 64'd131072 + tot_u / 64'd2, tot_u);
        if (neg) rom[n] = (q > 64'd131072) ? CoefMin : coef_t'(CoefW'(64'd0 - q));
        else rom[n] = (q > 64'd131071) ? CoefMax : coef_t'(CoefW'(q));
      end
    end
    return rom;
  endfunction

  localparam coef_rom_t CoefRom = build_rom();

endpackage

>>> hdl/wsfd_stream_if.sv
interface wsfd_in_if import wsfd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface wsfd_out_if import wsfd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

>>> hdl/wsfd_delay_ram.sv
module wsfd_delay_ram import wsfd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [TapW-1:0] wr_addr_i,
  input  sample_t         wr_data_i,
  input  logic            rd_en_i,
  input  logic [TapW-1:0] rd_addr_i,
  output sample_t         rd_data_o
);

  sample_t         mem_q [TAPS];
  sample_t         rd_data_q;
  logic [TAPS-1:0] vld_q;
  logic            rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_q <= mem_q[rd_addr_i];
  end

  // never-written entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) vld_q[wr_addr_i] <= 1'b1;
      if (rd_en_i) rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

>>> hdl/wsfd_mac.sv
module wsfd_mac import wsfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mac_ctrl_t ctrl_i,
  input  sample_t   smp_i,
  input  coef_t     coef_i,
  output sample_t   result_o
);

  localparam int ShW = AccW + 1 - RoundSh;

  logic signed [ProdW-1:0] prod_q;
  logic                    prod_vld_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW:0]    rnd;
  logic [ShW-1:0]          shr;
  logic [ShW-SampleW:0]    hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) prod_q <= smp_i * coef_i;
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end

  // round half up, floor shift, saturate to the sample range
  always_comb begin
    rnd = {acc_q[AccW-1], acc_q} + (AccW+1)'(1 << (RoundSh - 1));
    shr = rnd[AccW:RoundSh];
    hi  = shr[ShW-1:SampleW-1];
    if ((&hi) || !(|hi)) begin
      result_o = sample_t'(shr[SampleW-1:0]);
    end else if (shr[ShW-1]) begin
      result_o = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(SampleW-1){1'b1}}};
    end
  end

endmodule

>>> hdl/windowed_sinc_fir_decimator.sv
// Channel   Dir  Payload           Accepted when
// in_i      in   sample_in  s24    in_i.valid && in_i.ready
// out_o     out  sample_out s24    out_o.valid && out_o.ready
//
// An item that does not complete a decimation group leaves ready high.
// The item that completes a group holds ready low while one shared 24x18
// multiply-accumulate walks the delay line one tap a cycle, then StDrain
// drains the read and product registers and StFin loads the result.
// Reset (async, active low) clears the delay line through per-entry valid bits.
// The load waits while the previous result is untaken, stretching that item.
module windowed_sinc_fir_decimator import wsfd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  wsfd_in_if.sink   in_i,
  wsfd_out_if.source out_o
);

  typedef enum logic [1:0] {StIdle, StRun, StDrain, StFin} state_e;

  state_e          state_q;
  logic [TapW-1:0] wp_q;
  logic [PhW-1:0]  phase_q;
  logic [TapW-1:0] rd_addr_q;
  logic [TapW-1:0] tap_q;
  logic            drain_q;
  logic            rd_vld_q;
  logic            out_vld_q;
  sample_t         out_data_q;
  coef_t           coef_q;

  logic            accept;
  logic            phase_last;
  logic [TapW-1:0] wp_nxt;
  logic [TapW-1:0] rd_addr_nxt;
  sample_t         ram_rd_data;
  sample_t         mac_result;
  mac_ctrl_t       mac_ctrl;

  assign in_i.ready  = (state_q == StIdle);
  assign accept      = in_i.valid && in_i.ready;
  assign phase_last  = (phase_q == PhW'(OVERSAMPLE - 1));
  assign wp_nxt      = (wp_q == TapW'(TAPS - 1)) ? '0 : wp_q + 1'b1;
  assign rd_addr_nxt = (rd_addr_q == TapW'(TAPS - 1)) ? '0 : rd_addr_q + 1'b1;

  assign mac_ctrl.clr    = accept && phase_last;
  assign mac_ctrl.mul_en = rd_vld_q;

  assign out_o.valid      = out_vld_q;
  assign out_o.sample_out = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      wp_q       <= '0;
      phase_q    <= '0;
      rd_addr_q  <= '0;
      tap_q      <= '0;
      drain_q    <= 1'b0;
      rd_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      rd_vld_q <= (state_q == StRun);
      if (out_vld_q && out_o.ready && (state_q != StFin)) out_vld_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            wp_q    <= wp_nxt;
            phase_q <= phase_last ? '0 : phase_q + 1'b1;
            if (phase_last) begin
              // oldest sample sits at the slot after the newest
              state_q   <= StRun;
              rd_addr_q <= wp_nxt;
              tap_q     <= TapW'(TAPS - 1);
            end
          end
        end
        StRun: begin
          rd_addr_q <= rd_addr_nxt;
          if (tap_q == '0) begin
            state_q <= StDrain;
            drain_q <= 1'b0;
          end else begin
            tap_q <= tap_q - 1'b1;
          end
        end
        StDrain: begin
          drain_q <= 1'b1;
          if (drain_q) state_q <= StFin;
        end
        StFin: begin
          if (!out_vld_q || out_o.ready) begin
            out_vld_q  <= 1'b1;
            out_data_q <= mac_result;
            state_q    <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q <= CoefRom[tap_q];
  end

  wsfd_delay_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_addr_i (wp_q),
    .wr_data_i (in_i.sample_in),
    .rd_en_i   (state_q == StRun),
    .rd_addr_i (rd_addr_q),
    .rd_data_o (ram_rd_data)
  );

  wsfd_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .smp_i    (ram_rd_data),
    .coef_i   (coef_q),
    .result_o (mac_result)
  );

endmodule

>>> hdl/wsfd_checker.sv
`include "windowed_sinc_fir_decimator_defines.svh"

module wsfd_checker import wsfd_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input sample_t out_data_i
);

  `WSFD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped before taken")
  `WSFD_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_data_i), "result changed while stalled")
  `WSFD_ASSERT_SAME(a_out_after_busy, $rose(out_valid_i), $past(!in_ready_i), "result appeared without a busy phase")
  `WSFD_ASSERT_SAME(a_busy_after_item, $fell(in_ready_i), $past(in_valid_i && in_ready_i), "busy without an accepted item")

endmodule

bind windowed_sinc_fir_decimator wsfd_checker u_wsfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.sample_out)
);
